// ----- src/unicode_escape_to_utf8_assert.svh -----
// Assertion macros shared by the command queue and back end modules.
// Expects a clock named clock and an active-high reset named reset in scope.
`ifndef UNICODE_ESCAPE_TO_UTF8_ASSERT_SVH
`define UNICODE_ESCAPE_TO_UTF8_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define UE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check that a condition never holds outside reset.
`define UE_ASSERT_NEVER(label, cond, msg) \
   `UE_ASSERT(label, !(cond), msg)

`endif

// ----- src/ue2u_pkg.sv -----
// Shared types, constants and helpers of the unicode escape decoder.
// No dependencies; used by every module of the block.
`default_nettype none

package ue2u_pkg;

   // Largest number of output bytes that one input byte can release
   localparam int unsigned MaxOut   = 6;
   // Default depth of the command queue between front and back
   localparam int unsigned CmdDepth = 4;
   // Number of held hex digit bytes
   localparam int unsigned HeldDepth = 3;

   localparam logic [7:0] CharBackslash = 8'h5C;
   localparam logic [7:0] CharU         = 8'h75;

   // Match phase codes
   localparam logic [2:0] PhaseIdle  = 3'd0;
   localparam logic [2:0] PhaseSlash = 3'd1;
   localparam logic [2:0] PhaseU     = 3'd2;
   localparam logic [2:0] PhaseDig1  = 3'd3;
   localparam logic [2:0] PhaseDig2  = 3'd4;
   localparam logic [2:0] PhaseDig3  = 3'd5;

   // One queued command: a run of output bytes released by one input byte
   typedef struct packed {
      logic [MaxOut-1:0][7:0] data;
      logic [2:0]             count;
      logic                   last;
   } cmd_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   // Decode one ASCII hex digit of either case
   function automatic hex_type hex_decode(input logic [7:0] b);
      hex_type r;
      r.ok  = 1'b0;
      r.val = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r.ok  = 1'b1;
         r.val = b[3:0];
      end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
         r.ok  = 1'b1;
         r.val = b[3:0] + 4'd9;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- src/unicode_escape_to_utf8.sv -----
// Top level of the \uXXXX escape to UTF-8 decoder.
// Depends on ue2u_pkg, ue2u_front, ue2u_cmd_fifo and ue2u_back.
//
//   channel  handshake         payload
//   req      req_push/req_full req_in_byte, req_in_last
//   rsp      rsp_pop/rsp_empty rsp_out_byte, rsp_out_last
//
// One input byte is taken per cycle while the command queue has room.
// The back end sends one output byte per cycle while the result side keeps popping;
// the output bytes of one input byte leave in turn, and the first passes through the
// command queue and then the output register before it reaches the result ports.
// Synchronous reset clears the match state, the queue and the output valid flag.
// A stalled result side fills the CMD_DEPTH-entry queue, then raises req_full.
`default_nettype none

module unicode_escape_to_utf8 #(
   parameter int unsigned CMD_DEPTH = ue2u_pkg::CmdDepth
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_last
);

   logic              accept;
   ue2u_pkg::cmd_type front_cmd;
   logic              front_valid;
   ue2u_pkg::cmd_type head_cmd;
   logic              q_empty;
   logic              q_full;
   logic              head_done;
   logic              out_valid;

   // Take a beat when the queue has room
   assign accept    = req_push && !q_full;
   assign req_full  = q_full;
   assign rsp_empty = !out_valid;

   ue2u_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .in_last   (req_in_last),
      .cmd       (front_cmd),
      .cmd_valid (front_valid)
   );

   ue2u_cmd_fifo #(
      .DEPTH (CMD_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_valid),
      .wr_data (front_cmd),
      .rd_en   (head_done),
      .rd_data (head_cmd),
      .empty   (q_empty),
      .full    (q_full)
   );

   ue2u_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head_cmd),
      .head_valid (!q_empty),
      .head_done  (head_done),
      .pop        (rsp_pop),
      .out_valid  (out_valid),
      .out_byte   (rsp_out_byte),
      .out_last   (rsp_out_last)
   );

endmodule

`default_nettype wire

// ----- src/ue2u_front.sv -----
// Front end: tracks the escape match and turns each accepted byte into a
// command of zero to six output bytes. Depends on ue2u_pkg.
`default_nettype none

module ue2u_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        in_byte,
   input  wire logic              in_last,
   output ue2u_pkg::cmd_type      cmd,
   output logic                   cmd_valid
);

   logic [2:0]  phase_ff, phase_in;
   logic [11:0] accum_ff, accum_in;
   logic [ue2u_pkg::HeldDepth-1:0][7:0] held_ff, held_in;

   logic [2:0]       phase;
   ue2u_pkg::hex_type hex;
   logic             fail;
   logic             emit_b;
   logic             emit_cp;
   logic [15:0]      cp;
   logic [2:0]       k;
   logic [ue2u_pkg::MaxOut-1:0][7:0] data;
   logic [4:0][7:0]  pend;
   logic [1:0]       held_idx;
   logic [2:0]       after_phase;

   // Classify the byte and build the output run
   always_comb begin
      phase    = (phase_ff > ue2u_pkg::PhaseDig3) ? ue2u_pkg::PhaseIdle : phase_ff;
      hex      = ue2u_pkg::hex_decode(in_byte);
      held_in  = held_ff;
      accum_in = accum_ff;
      fail     = 1'b0;
      emit_b   = 1'b0;
      emit_cp  = 1'b0;
      held_idx = 2'(phase - ue2u_pkg::PhaseU);
      cp       = {accum_ff, hex.val};
      after_phase = phase;

      if (phase == ue2u_pkg::PhaseIdle) begin
         if (in_byte == ue2u_pkg::CharBackslash) after_phase = ue2u_pkg::PhaseSlash;
         else emit_b = 1'b1;
      end else if (phase == ue2u_pkg::PhaseSlash) begin
         if (in_byte == ue2u_pkg::CharU) after_phase = ue2u_pkg::PhaseU;
         else fail = 1'b1;
      end else if (phase != ue2u_pkg::PhaseDig3) begin
         if (hex.ok) begin
            held_in[held_idx] = in_byte;
            accum_in          = {accum_ff[7:0], hex.val};
            after_phase       = phase + 3'd1;
         end else begin
            fail = 1'b1;
         end
      end else begin
         if (hex.ok) begin
            emit_cp     = 1'b1;
            after_phase = ue2u_pkg::PhaseIdle;
            accum_in    = '0;
         end else begin
            fail = 1'b1;
         end
      end

      pend[0] = ue2u_pkg::CharBackslash;
      pend[1] = ue2u_pkg::CharU;
      pend[2] = held_in[0];
      pend[3] = held_in[1];
      pend[4] = held_in[2];

      k    = 3'd0;
      data = '0;

      // Flush the failed partial match, then restart or pass the byte
      if (fail) begin
         for (int i = 0; i < 5; i++) begin
            if (3'(i) < phase) begin
               data[k] = pend[i];
               k       = k + 3'd1;
            end
         end
         accum_in = '0;
         if (in_byte == ue2u_pkg::CharBackslash) begin
            after_phase = ue2u_pkg::PhaseSlash;
         end else begin
            after_phase = ue2u_pkg::PhaseIdle;
            emit_b      = 1'b1;
         end
      end

      if (emit_b) begin
         data[k] = in_byte;
         k       = k + 3'd1;
      end

      // Encode the completed code point as UTF-8
      if (emit_cp) begin
         if (cp[15:7] == '0) begin
            data[k] = {1'b0, cp[6:0]};
            k       = k + 3'd1;
         end else if (cp[15:11] == '0) begin
            data[k] = {3'b110, cp[10:6]};
            k       = k + 3'd1;
            data[k] = {2'b10, cp[5:0]};
            k       = k + 3'd1;
         end else begin
            data[k] = {4'b1110, cp[15:12]};
            k       = k + 3'd1;
            data[k] = {2'b10, cp[11:6]};
            k       = k + 3'd1;
            data[k] = {2'b10, cp[5:0]};
            k       = k + 3'd1;
         end
      end

      // Flush whatever match is still open at the end of the string
      phase_in = after_phase;
      if (in_last) begin
         for (int i = 0; i < 5; i++) begin
            if (3'(i) < after_phase) begin
               data[k] = pend[i];
               k       = k + 3'd1;
            end
         end
         phase_in = ue2u_pkg::PhaseIdle;
         accum_in = '0;
      end
   end

   assign cmd.data  = data;
   assign cmd.count = k;
   assign cmd.last  = in_last;
   assign cmd_valid = accept && (k != 3'd0);

   // Advance the match state on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ue2u_pkg::PhaseIdle;
         accum_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
      end
   end

   // Hold digit bytes for a possible flush
   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/ue2u_cmd_fifo.sv -----
// Short command queue between the front and back ends.
// Depends on ue2u_pkg and the assertion header.
`default_nettype none
`include "unicode_escape_to_utf8_assert.svh"

module ue2u_cmd_fifo #(
   parameter int unsigned DEPTH = ue2u_pkg::CmdDepth
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire ue2u_pkg::cmd_type wr_data,
   input  wire logic              rd_en,
   output ue2u_pkg::cmd_type      rd_data,
   output logic                   empty,
   output logic                   full
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   ue2u_pkg::cmd_type mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CntW'(DEPTH));
   assign rd_data = mem_ff[rd_ptr_ff];

   // Step pointers with wrap and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming command
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `UE_ASSERT(a_fifo_bound, count_ff <= CntW'(DEPTH), "command queue over its depth")
   `UE_ASSERT_NEVER(a_fifo_underrun, rd_en && empty, "command read from empty queue")
   `UE_ASSERT(a_fifo_grow, wr_en && !rd_en |=> count_ff == $past(count_ff) + 1'b1, "no growth")

endmodule

`default_nettype wire

// ----- src/ue2u_back.sv -----
// Back end: walks the head command one byte per cycle into the output register
// while it is empty or popped. Depends on ue2u_pkg and the assertion header.
`default_nettype none
`include "unicode_escape_to_utf8_assert.svh"

module ue2u_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ue2u_pkg::cmd_type head,
   input  wire logic              head_valid,
   output logic                   head_done,
   input  wire logic              pop,
   output logic                   out_valid,
   output logic [7:0]             out_byte,
   output logic                   out_last
);

   logic [2:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff;
   logic       out_last_ff;
   logic       load;
   logic       take;
   logic       at_end;

   // Refill the output register when it is empty or being popped
   always_comb begin
      load         = !out_valid_ff || pop;
      take         = load && head_valid;
      at_end       = (idx_ff == head.count - 3'd1);
      head_done    = take && at_end;
      out_valid_in = load ? head_valid : out_valid_ff;
      idx_in       = idx_ff;
      if (take) begin
         idx_in = at_end ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the next beat
   always_ff @(posedge clock) begin
      if (take) begin
         out_byte_ff <= head.data[idx_ff];
         out_last_ff <= head.last && at_end;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_byte  = out_byte_ff;
   assign out_last  = out_last_ff;

   `UE_ASSERT(a_back_idx, head_valid |-> idx_ff < head.count, "byte index past command length")
   `UE_ASSERT(a_back_drain, $fell(out_valid_ff) |-> $past(pop), "beat dropped without pop")

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Testbench for unicode_escape_to_utf8: a directed table of escapes, then random text.
// Depends on ue2u_pkg and the unicode_escape_to_utf8 RTL; every output beat is checked.

module tb;

   localparam int WatchdogLimit = 3000;
   localparam int RandomItems   = 350;
   localparam int PhaseItems    = RandomItems / 3;
   localparam int TailCycles    = 16;
   localparam int DirectedRows  = 28;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } utf8_beat_type;

   // One directed input byte; typed rows carry their output bytes, first byte at index 0
   typedef struct packed {
      logic [7:0]      in_byte;
      logic            in_last;
      logic            typed;
      logic [2:0]      n_out;
      logic [0:5][7:0] outs;
   } script_row_type;

   localparam script_row_type DirectedScript [0:DirectedRows-1] = '{
      // byte extremes pass straight through
      '{8'h00, 1'b0, 1'b1, 3'd1, {8'h00, 40'h0}},
      '{8'hFF, 1'b1, 1'b1, 3'd1, {8'hFF, 40'h0}},
      // a second backslash flushes the first and restarts; \uFFFF is the top code point
      '{ue2u_pkg::CharBackslash, 1'b0, 1'b0, 3'd0, 48'h0},
      '{ue2u_pkg::CharBackslash, 1'b0, 1'b1, 3'd1, {ue2u_pkg::CharBackslash, 40'h0}},
      '{ue2u_pkg::CharU, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'h46, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'h46, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'h46, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'h46, 1'b0, 1'b1, 3'd3, {24'hEFBFBF, 24'h0}},
      // \u07ff in lower case: largest two-byte value
      '{ue2u_pkg::CharBackslash, 1'b0, 1'b0, 3'd0, 48'h0},
      '{ue2u_pkg::CharU, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'h30, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'h37, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'h66, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'h66, 1'b0, 1'b1, 3'd2, {16'hDFBF, 32'h0}},
      // broken escape: held bytes come back out, then the offending byte
      '{ue2u_pkg::CharBackslash, 1'b0, 1'b0, 3'd0, 48'h0},
      '{ue2u_pkg::CharU, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'h30, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'h67, 1'b0, 1'b1, 3'd4, {32'h5C753067, 16'h0}},
      // string ends inside an escape
      '{ue2u_pkg::CharBackslash, 1'b0, 1'b0, 3'd0, 48'h0},
      '{ue2u_pkg::CharU, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'h64, 1'b1, 1'b1, 3'd3, {24'h5C7564, 24'h0}},
      // surrogate code point closes the string
      '{ue2u_pkg::CharBackslash, 1'b0, 1'b0, 3'd0, 48'h0},
      '{ue2u_pkg::CharU, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'h64, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'h38, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'h30, 1'b0, 1'b0, 3'd0, 48'h0},
      '{8'h30, 1'b1, 1'b0, 3'd0, 48'h0}
   };

   logic       clock;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic [7:0] req_in_byte;
   logic       req_in_last;
   logic       rsp_empty;
   logic       rsp_pop;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;

   // Decoder state as the predictor sees it
   logic [2:0]    esc_phase;
   logic [7:0]    esc_digits [3];
   logic [11:0]   esc_code;
   utf8_beat_type step_out [$];
   utf8_beat_type utf8_expect_q [$];

   int send_idle_pct;
   int recv_idle_pct;
   int rsp_hold_cycles;
   int mismatch_count;
   int items_sent;

   unicode_escape_to_utf8 dut (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Value of an ASCII hex digit of either case, -1 for anything else
   function automatic int hex_nibble(input logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
      if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
      if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
      return -1;
   endfunction

   task automatic emit(input logic [7:0] b);
      utf8_beat_type beat;
      beat.data = b;
      beat.last = 1'b0;
      step_out.push_back(beat);
   endtask

   // Send the pending partial match back out as received and go idle
   task automatic flush_partial();
      int i;
      if (esc_phase >= ue2u_pkg::PhaseSlash) emit(ue2u_pkg::CharBackslash);
      if (esc_phase >= ue2u_pkg::PhaseU) emit(ue2u_pkg::CharU);
      for (i = 0; i + 2 < int'(esc_phase) && i < 3; i++) emit(esc_digits[i]);
      esc_phase = ue2u_pkg::PhaseIdle;
      esc_code  = '0;
   endtask

   task automatic emit_utf8(input logic [15:0] cp);
      if (cp < 16'h0080) begin
         emit(cp[7:0]);
      end else if (cp < 16'h0800) begin
         emit({3'b110, cp[10:6]});
         emit({2'b10, cp[5:0]});
      end else begin
         emit({4'b1110, cp[15:12]});
         emit({2'b10, cp[11:6]});
         emit({2'b10, cp[5:0]});
      end
   endtask

   // Predict the output beats caused by one input byte into step_out
   task automatic decode_escape_byte(input logic [7:0] b, input logic l);
      int d;
      bit ok;
      d  = hex_nibble(b);
      ok = 1'b1;
      step_out.delete();
      if (esc_phase > ue2u_pkg::PhaseDig3) esc_phase = ue2u_pkg::PhaseIdle;
      case (esc_phase)
         ue2u_pkg::PhaseIdle: begin
            if (b == ue2u_pkg::CharBackslash) esc_phase = ue2u_pkg::PhaseSlash;
            else emit(b);
         end
         ue2u_pkg::PhaseSlash: begin
            ok = (b == ue2u_pkg::CharU);
            if (ok) esc_phase = ue2u_pkg::PhaseU;
         end
         ue2u_pkg::PhaseDig3: begin
            ok = (d >= 0);
            if (ok) begin
               emit_utf8({esc_code, d[3:0]});
               esc_phase = ue2u_pkg::PhaseIdle;
               esc_code  = '0;
            end
         end
         default: begin
            // hold the first three digits and accumulate their value
            ok = (d >= 0);
            if (ok) begin
               esc_digits[esc_phase - ue2u_pkg::PhaseU] = b;
               esc_code  = {esc_code[7:0], d[3:0]};
               esc_phase = esc_phase + 3'd1;
            end
         end
      endcase
      if (!ok) begin
         flush_partial();
         if (b == ue2u_pkg::CharBackslash) esc_phase = ue2u_pkg::PhaseSlash;
         else emit(b);
      end
      if (l) begin
         flush_partial();
         if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      end
   endtask

   // Offer one input beat, wait for it to be taken, then record what it should produce
   task automatic push_text_byte(input logic [7:0] b, input logic l, input bit typed,
                                 input int n_out, input logic [0:5][7:0] outs);
      int            i;
      utf8_beat_type beat;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_push <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_push    <= 1'b1;
      req_in_byte <= b;
      req_in_last <= l;
      @(posedge clock);
      while (req_full) @(posedge clock);
      decode_escape_byte(b, l);
      if (typed) begin
         for (i = 0; i < n_out; i++) begin
            beat.data = outs[i];
            beat.last = l && (i == n_out - 1);
            utf8_expect_q.push_back(beat);
         end
      end else begin
         for (i = 0; i < step_out.size(); i++) utf8_expect_q.push_back(step_out[i]);
      end
      items_sent++;
   endtask

   task automatic send_text(input logic [7:0] b, input logic l);
      push_text_byte(b, l, 1'b0, 0, '0);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return 8'h30 + 8'(v);
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
   endfunction

   // Random text: mostly well-formed escapes, some plain bytes, broken and cut escapes
   task automatic send_random_text(input int n_items);
      int          target;
      int          kind;
      int          len;
      int          i;
      bit          end_str;
      logic [15:0] cp;
      logic [7:0]  word [$];
      target = items_sent + n_items;
      while (items_sent < target) begin
         word.delete();
         kind    = $urandom_range(0, 19);
         end_str = ($urandom_range(0, 5) == 0);
         if (kind < 12) begin
            // bias toward one- and two-byte encodings as well
            case ($urandom_range(0, 2))
               0:       cp = 16'($urandom());
               1:       cp = 16'($urandom_range(0, 'h7FF));
               default: cp = 16'($urandom_range(0, 'h7F));
            endcase
            word.push_back(ue2u_pkg::CharBackslash);
            word.push_back(ue2u_pkg::CharU);
            for (i = 12; i >= 0; i -= 4) word.push_back(hex_char(cp[i +: 4]));
         end else if (kind < 16) begin
            len = $urandom_range(1, 3);
            repeat (len) word.push_back(8'($urandom_range(0, 255)));
         end else begin
            // escape prefix of one to five bytes
            len = $urandom_range(1, 5);
            word.push_back(ue2u_pkg::CharBackslash);
            if (len > 1) word.push_back(ue2u_pkg::CharU);
            for (i = 2; i < len; i++) word.push_back(hex_char(4'($urandom_range(0, 15))));
            if (kind < 19) begin
               if ($urandom_range(0, 2) == 0) word.push_back(ue2u_pkg::CharBackslash);
               else word.push_back(8'($urandom_range(0, 255)));
            end else begin
               end_str = 1'b1;
            end
         end
         for (i = 0; i < word.size(); i++) send_text(word[i], end_str && (i == word.size() - 1));
      end
   endtask

   // Receiver: pop at random, or hold off for a counted stretch when asked
   initial begin
      rsp_pop = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Compare each accepted result beat with the oldest expectation
   always @(posedge clock) begin
      utf8_beat_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (utf8_expect_q.size() == 0) begin
            $display("%0t: unexpected beat: expected none, got byte %h last %b",
                     $time, rsp_out_byte, rsp_out_last);
            mismatch_count++;
         end else begin
            want = utf8_expect_q.pop_front();
            if (rsp_out_byte !== want.data) begin
               $display("%0t: out_byte mismatch: expected %h, got %h",
                        $time, want.data, rsp_out_byte);
               mismatch_count++;
            end
            if (rsp_out_last !== want.last) begin
               $display("%0t: out_last mismatch: expected %b, got %b",
                        $time, want.last, rsp_out_last);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves on either side for too long
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WatchdogLimit) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet = 0;
         else quiet++;
      end
      $display("%0t: no beat accepted for %0d cycles", $time, WatchdogLimit);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int r;
      reset           = 1'b1;
      req_push        = 1'b0;
      req_in_byte     = 8'h00;
      req_in_last     = 1'b0;
      send_idle_pct   = 7;
      recv_idle_pct   = 62;
      rsp_hold_cycles = 0;
      mismatch_count  = 0;
      items_sent      = 0;
      esc_phase       = ue2u_pkg::PhaseIdle;
      esc_code        = '0;
      esc_digits      = '{default: 8'h00};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (r = 0; r < DirectedRows; r++)
         push_text_byte(DirectedScript[r].in_byte, DirectedScript[r].in_last,
                        DirectedScript[r].typed, DirectedScript[r].n_out,
                        DirectedScript[r].outs);

      // random text under three idling patterns
      send_random_text(PhaseItems);
      send_idle_pct = 62;
      recv_idle_pct = 7;
      send_random_text(PhaseItems);
      send_idle_pct   = 0;
      recv_idle_pct   = 0;
      rsp_hold_cycles = 80;
      send_random_text(RandomItems - 2 * PhaseItems);

      // drain
      @(negedge clock);
      req_push <= 1'b0;
      while (utf8_expect_q.size() != 0) @(negedge clock);
      repeat (TailCycles) @(posedge clock);
      if (mismatch_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
